// File: src/kdj_pkg.sv
// Package for the KDJ stochastic oscillator: widths, fixed-point constants,
// register indexes and the struct passed from the front to the back part.
// No dependencies.
`timescale 1ns / 1ps
package kdj_pkg;
  localparam int PriceW = 32;
  localparam int ValW   = 23;
  localparam int JW     = 26;
  localparam int CfgW   = 8;
  localparam int WinMaxDefault = 64;

  localparam logic [ValW-1:0] FixedHundred = ValW'(100 * 65536);
  localparam logic [ValW-1:0] FixedFifty   = ValW'(50 * 65536);

  localparam logic [1:0] RegWindow = 2'd0;
  localparam logic [1:0] RegKSmooth = 2'd1;
  localparam logic [1:0] RegDSmooth = 2'd2;

  // Work handed from the window scan to the smoothing unit.
  typedef struct packed {
    logic [PriceW-1:0] close;
    logic [PriceW-1:0] highest;
    logic [PriceW-1:0] lowest;
  } scan_t;
endpackage

// File: src/kdj_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module kdj_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: src/kdj_front.sv
// Front part: stores each bar into the window RAMs and scans the window for
// the highest high and lowest low. Uses kdj_pkg and kdj_ram.
`timescale 1ns / 1ps
module kdj_front #(
  parameter int WindowMax = kdj_pkg::WinMaxDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [kdj_pkg::PriceW-1:0]  bar_high_i,
  input  logic [kdj_pkg::PriceW-1:0]  bar_low_i,
  input  logic [kdj_pkg::PriceW-1:0]  bar_close_i,
  input  logic [$clog2(WindowMax+1)-1:0] win_len_i,
  output logic                        scan_valid_o,
  input  logic                        scan_ready_i,
  output kdj_pkg::scan_t              scan_o
);
  localparam int AW = $clog2(WindowMax);
  localparam int CW = $clog2(WindowMax + 1);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [AW-1:0] wslot_q, wslot_d, raddr_q, raddr_d;
  logic [CW-1:0] fill_q, fill_d, cnt_q, cnt_d;
  logic          rvalid_q, rvalid_d;
  logic [kdj_pkg::PriceW-1:0] hi_q, hi_d, lo_q, lo_d, close_q, close_d;
  logic [kdj_pkg::PriceW-1:0] hi_rd, lo_rd;
  logic accept;
  logic [CW-1:0] len_eff;
  logic [CW-1:0] fill_next;

  assign accept = push_i && !full_o;
  assign full_o = (state_q != StIdle);

  always_comb begin
    if (win_len_i < CW'(2)) len_eff = CW'(2);
    else if (win_len_i > CW'(WindowMax)) len_eff = CW'(WindowMax);
    else len_eff = win_len_i;
    fill_next = (fill_q < CW'(WindowMax)) ? fill_q + CW'(1) : fill_q;
  end

  kdj_ram #(.Width(kdj_pkg::PriceW), .Depth(WindowMax)) u_high (
    .clk_i, .we_i(accept), .waddr_i(wslot_q), .wdata_i(bar_high_i),
    .raddr_i(raddr_q), .rdata_o(hi_rd));
  kdj_ram #(.Width(kdj_pkg::PriceW), .Depth(WindowMax)) u_low (
    .clk_i, .we_i(accept), .waddr_i(wslot_q), .wdata_i(bar_low_i),
    .raddr_i(raddr_q), .rdata_o(lo_rd));

  always_comb begin
    state_d = state_q; wslot_d = wslot_q; raddr_d = raddr_q; fill_d = fill_q;
    cnt_d = cnt_q; rvalid_d = 1'b0;
    hi_d = hi_q; lo_d = lo_q; close_d = close_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          wslot_d = (wslot_q == AW'(WindowMax - 1)) ? '0 : wslot_q + AW'(1);
          fill_d  = fill_next;
          close_d = bar_close_i;
          hi_d = '0; lo_d = '1;
          if (fill_next >= len_eff) begin
            // Start the scan at the slot just written so the new bar is seen.
            raddr_d = wslot_q; cnt_d = len_eff;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (cnt_q != '0) begin
          raddr_d = (raddr_q == '0) ? AW'(WindowMax - 1) : raddr_q - AW'(1);
          cnt_d = cnt_q - CW'(1);
          rvalid_d = 1'b1;
        end
        if (rvalid_q) begin
          if (hi_rd > hi_q) hi_d = hi_rd;
          if (lo_rd < lo_q) lo_d = lo_rd;
        end
        if (cnt_q == '0 && !rvalid_q) state_d = StOut;
      end
      StOut: if (scan_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; wslot_q <= '0; fill_q <= '0; rvalid_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d; wslot_q <= wslot_d; fill_q <= fill_d;
      rvalid_q <= rvalid_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= raddr_d;
    hi_q <= hi_d; lo_q <= lo_d; close_q <= close_d;
  end

  assign scan_valid_o = (state_q == StOut);
  assign scan_o = '{close: close_q, highest: hi_q, lowest: lo_q};
endmodule

// File: src/kdj_back.sv
// Back part: RSV by restoring division or saturation to 0 or 100, then K and D
// smoothing by serial division, with a one-entry result register. Uses kdj_pkg.
`timescale 1ns / 1ps
module kdj_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        scan_valid_i,
  output logic                        scan_ready_o,
  input  kdj_pkg::scan_t              scan_i,
  input  logic [kdj_pkg::CfgW-1:0]    k_smooth_i,
  input  logic [kdj_pkg::CfgW-1:0]    d_smooth_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [kdj_pkg::ValW-1:0]    k_value_o,
  output logic [kdj_pkg::ValW-1:0]    d_value_o,
  output logic signed [kdj_pkg::JW-1:0] j_value_o
);
  localparam int VW = kdj_pkg::ValW;
  localparam int NW = 56;  // dividend width covers 32-bit * 100.0 and smoothing sums
  localparam int DW = 33;
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRsvMul = 3'd1;
  localparam logic [2:0] StDiv = 3'd2;
  localparam logic [2:0] StKMul = 3'd3;
  localparam logic [2:0] StDMul = 3'd4;
  localparam logic [2:0] StDone = 3'd5;
  localparam logic [1:0] PhRsv = 2'd0;
  localparam logic [1:0] PhK = 2'd1;
  localparam logic [1:0] PhD = 2'd2;

  logic [2:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic [NW-1:0] num_q, num_d;
  logic [DW-1:0] rem_q, rem_d, den_q, den_d;
  logic [5:0] bit_q, bit_d;
  logic [kdj_pkg::PriceW-1:0] diff_q, diff_d;
  logic [VW-1:0] rsv_q, rsv_d, k_q, k_d, d_q, d_d;
  logic [VW-1:0] pk_q, pk_d, pd_q, pd_d;
  logic have_q, have_d, outv_q, outv_d;
  logic [VW-1:0] ko_q, ko_d, do_q, do_d;
  logic signed [kdj_pkg::JW-1:0] jo_q, jo_d;
  logic [DW-1:0] trial;
  logic [kdj_pkg::CfgW-1:0] ka, da;
  logic [VW-1:0] pk_use, pd_use;

  assign ka = (k_smooth_i == '0) ? kdj_pkg::CfgW'(1) : k_smooth_i;
  assign da = (d_smooth_i == '0) ? kdj_pkg::CfgW'(1) : d_smooth_i;
  assign pk_use = have_q ? pk_q : kdj_pkg::FixedFifty;
  assign pd_use = have_q ? pd_q : kdj_pkg::FixedFifty;
  assign scan_ready_o = (state_q == StIdle) && !outv_q;
  assign trial = {rem_q[DW-2:0], num_q[NW-1]};

  always_comb begin
    state_d = state_q; phase_d = phase_q; num_d = num_q; rem_d = rem_q;
    den_d = den_q; bit_d = bit_q; diff_d = diff_q; rsv_d = rsv_q;
    k_d = k_q; d_d = d_q; pk_d = pk_q; pd_d = pd_q; have_d = have_q;
    outv_d = outv_q && !pop_i; ko_d = ko_q; do_d = do_q; jo_d = jo_q;
    case (state_q)
      StIdle: begin
        if (scan_valid_i && !outv_q) begin
          if (scan_i.highest <= scan_i.lowest || scan_i.close <= scan_i.lowest) begin
            rsv_d = '0; state_d = StKMul;
          end else if (scan_i.close >= scan_i.highest) begin
            rsv_d = kdj_pkg::FixedHundred; state_d = StKMul;
          end else begin
            diff_d = scan_i.close - scan_i.lowest;
            den_d = DW'(scan_i.highest - scan_i.lowest);
            state_d = StRsvMul;
          end
        end
      end
      StRsvMul: begin
        num_d = NW'(diff_q) * NW'(kdj_pkg::FixedHundred);
        rem_d = '0; bit_d = 6'(NW); phase_d = PhRsv; state_d = StDiv;
      end
      StKMul: begin
        num_d = NW'(ka - kdj_pkg::CfgW'(1)) * NW'(pk_use) + NW'(rsv_q);
        den_d = DW'(ka); rem_d = '0; bit_d = 6'(NW); phase_d = PhK; state_d = StDiv;
      end
      StDMul: begin
        num_d = NW'(da - kdj_pkg::CfgW'(1)) * NW'(pd_use) + NW'(k_q);
        den_d = DW'(da); rem_d = '0; bit_d = 6'(NW); phase_d = PhD; state_d = StDiv;
      end
      StDiv: begin
        // One quotient bit per cycle; quotient bits shift into num.
        if (trial >= den_q) begin
          rem_d = trial - den_q;
          num_d = {num_q[NW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          num_d = {num_q[NW-2:0], 1'b0};
        end
        bit_d = bit_q - 6'd1;
        if (bit_q == 6'd1) begin
          case (phase_q)
            PhRsv: begin rsv_d = num_d[VW-1:0]; state_d = StKMul; end
            PhK: begin k_d = num_d[VW-1:0]; state_d = StDMul; end
            default: begin d_d = num_d[VW-1:0]; state_d = StDone; end
          endcase
        end
      end
      StDone: begin
        if (!outv_q) begin
          pk_d = k_q; pd_d = d_q; have_d = 1'b1;
          ko_d = k_q; do_d = d_q;
          jo_d = $signed(kdj_pkg::JW'(k_q) * kdj_pkg::JW'(3))
               - $signed(kdj_pkg::JW'(d_q) * kdj_pkg::JW'(2));
          outv_d = 1'b1; state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; have_q <= 1'b0; outv_q <= 1'b0;
      pk_q <= '0; pd_q <= '0;
    end else begin
      state_q <= state_d; have_q <= have_d; outv_q <= outv_d;
      pk_q <= pk_d; pd_q <= pd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d; num_q <= num_d; rem_q <= rem_d; den_q <= den_d;
    bit_q <= bit_d; diff_q <= diff_d; rsv_q <= rsv_d; k_q <= k_d; d_q <= d_d;
    ko_q <= ko_d; do_q <= do_d; jo_q <= jo_d;
  end

  assign empty_o = !outv_q;
  assign k_value_o = ko_q;
  assign d_value_o = do_q;
  assign j_value_o = jo_q;
endmodule

// File: src/kdj_stochastic_oscillator.sv
// Top level of the KDJ stochastic oscillator: configuration registers, the
// window front part and the arithmetic back part. Uses kdj_pkg and submodules.
//
//  channel  | handshake        | payload
//  input    | push / full      | bar_high_i, bar_low_i, bar_close_i
//  result   | empty / pop      | k_value_o, d_value_o, j_value_o
//  config   | cfg_we_i         | cfg_idx_i, cfg_data_i
//
// A bar is written into the window RAMs; a bar that completes a window is
// then scanned over the window RAM read port and handed over. The back
// part then runs its serial divider for RSV, K and D, skipping the RSV
// division when RSV saturates. Warm-up bars are only stored. The hand-over
// waits while the back part is busy or holds an unpopped result; the front
// takes no new bar until its scan result is handed over. Reset clears all
// control state and the seeding of K and D.
`timescale 1ns / 1ps
module kdj_stochastic_oscillator #(
  parameter int WindowMax = kdj_pkg::WinMaxDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  logic [kdj_pkg::PriceW-1:0] bar_high_i,
  input  logic [kdj_pkg::PriceW-1:0] bar_low_i,
  input  logic [kdj_pkg::PriceW-1:0] bar_close_i,
  output logic empty,
  input  logic pop,
  output logic [kdj_pkg::ValW-1:0] k_value_o,
  output logic [kdj_pkg::ValW-1:0] d_value_o,
  output logic signed [kdj_pkg::JW-1:0] j_value_o,
  input  logic cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [kdj_pkg::CfgW-1:0] cfg_data_i
);
  localparam int CW = $clog2(WindowMax + 1);
  logic [6:0] win_q;
  logic [kdj_pkg::CfgW-1:0] ks_q, ds_q;
  logic [CW-1:0] win_len;
  logic scan_valid, scan_ready;
  kdj_pkg::scan_t scan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 7'd9; ks_q <= 8'd3; ds_q <= 8'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kdj_pkg::RegWindow:  win_q <= cfg_data_i[6:0];
        kdj_pkg::RegKSmooth: ks_q <= cfg_data_i;
        kdj_pkg::RegDSmooth: ds_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp to what the window counter can hold; the front clamps further.
  assign win_len = (32'(win_q) > WindowMax) ? CW'(WindowMax) : CW'(win_q);

  kdj_front #(.WindowMax(WindowMax)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .bar_high_i, .bar_low_i, .bar_close_i, .win_len_i(win_len),
    .scan_valid_o(scan_valid), .scan_ready_i(scan_ready), .scan_o(scan));

  kdj_back u_back (
    .clk_i, .rst_ni, .scan_valid_i(scan_valid), .scan_ready_o(scan_ready),
    .scan_i(scan), .k_smooth_i(ks_q), .d_smooth_i(ds_q),
    .empty_o(empty), .pop_i(pop),
    .k_value_o, .d_value_o, .j_value_o);

`ifndef NO_ASSERTIONS
  a_j_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> j_value_o == $signed(26'(k_value_o) * 26'd3) - $signed(26'(d_value_o) * 26'd2))
    else $error("J does not match 3K-2D");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> k_value_o <= kdj_pkg::FixedHundred && d_value_o <= kdj_pkg::FixedHundred)
    else $error("K or D out of range");
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(k_value_o))
    else $error("result changed while waiting");
`endif
endmodule
